// ----- design/efb_pkg.sv -----
// Shared types and constants for the event fragment builder.
package efb_pkg;

   localparam int EVENT_W = 32;
   localparam int FRAG_W  = 16;
   localparam int WORDS_W = 22;
   localparam int COUNT_W = 7;

   localparam logic [WORDS_W-1:0]   WORDS_MAX    = '1;
   // a threshold of zero means one more than the count field can hold
   localparam logic [COUNT_W:0]     THRESH_ZERO  = 8'd128;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } efb_state_type;

   // one slot of the event table
   typedef struct packed {
      logic [EVENT_W-1:0] evt_num;
      logic [COUNT_W-1:0] count;
      logic [WORDS_W-1:0] words;
   } efb_entry_type;

   typedef struct packed {
      logic               complete;
      logic [COUNT_W-1:0] count;
      logic [WORDS_W-1:0] words;
   } efb_acc_type;

   typedef struct packed {
      logic               load;
      logic               complete;
      logic               dropped;
      logic               end_seen;
      logic [WORDS_W-1:0] words;
   } efb_res_type;

endpackage

// ----- design/efb_accum.sv -----
// Fragment count and saturating word sum for the selected slot.
module efb_accum (
   input  logic [efb_pkg::COUNT_W-1:0] fpe,
   input  logic [efb_pkg::COUNT_W-1:0] cur_count,
   input  logic [efb_pkg::WORDS_W-1:0] cur_words,
   input  logic [efb_pkg::FRAG_W-1:0]  frag_words,
   output efb_pkg::efb_acc_type        acc
);

   logic [efb_pkg::COUNT_W:0] thresh;
   logic [efb_pkg::COUNT_W:0] cnt;
   logic [efb_pkg::WORDS_W:0] sum;

   always_comb begin
      thresh = (fpe == '0) ? efb_pkg::THRESH_ZERO : {1'b0, fpe};
      cnt    = {1'b0, cur_count} + (efb_pkg::COUNT_W+1)'(1);
      sum    = {1'b0, cur_words} + (efb_pkg::WORDS_W+1)'(frag_words);
      acc.complete = (cnt >= thresh);
      acc.count    = cnt[efb_pkg::COUNT_W-1:0];
      acc.words    = (sum > {1'b0, efb_pkg::WORDS_MAX}) ? efb_pkg::WORDS_MAX
                                                        : sum[efb_pkg::WORDS_W-1:0];
   end

endmodule

// ----- design/efb_slot_ram.sv -----
// Slot table memory: one write port, one read port, registered read data.
module efb_slot_ram #(
   parameter int SLOTS = 16
) (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [$clog2(SLOTS)-1:0]     rd_addr,
   output efb_pkg::efb_entry_type       rd_data,
   input  logic                         wr_en,
   input  logic [$clog2(SLOTS)-1:0]     wr_addr,
   input  efb_pkg::efb_entry_type       wr_data
);

   efb_pkg::efb_entry_type mem_array [SLOTS];
   efb_pkg::efb_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_array[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/efb_ctrl.sv -----
// Sequencer: slot scan over the table memory, valid bits, update and result.
module efb_ctrl #(
   parameter int SLOTS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_accept,
   input  logic                         req_end,
   output logic                         req_ready,
   input  logic [efb_pkg::EVENT_W-1:0]  evt_num,
   input  logic [efb_pkg::FRAG_W-1:0]   frag_words,
   input  logic [efb_pkg::COUNT_W-1:0]  fpe,
   input  logic                         out_free,
   output logic                         rd_en,
   output logic [$clog2(SLOTS)-1:0]     rd_addr,
   input  efb_pkg::efb_entry_type       rd_data,
   output logic                         wr_en,
   output logic [$clog2(SLOTS)-1:0]     wr_addr,
   output efb_pkg::efb_entry_type       wr_data,
   output efb_pkg::efb_res_type         res
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   efb_pkg::efb_state_type state_ff, state_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [IDX_W-1:0]             chk_idx_ff, chk_idx_in;
   logic                         chk_vld_ff, chk_vld_in;
   logic [SLOTS-1:0]             valid_ff, valid_in;
   logic                         free_found_ff, free_found_in;
   logic [IDX_W-1:0]             free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]             tgt_idx_ff, tgt_idx_in;
   logic [efb_pkg::COUNT_W-1:0]  cur_count_ff, cur_count_in;
   logic [efb_pkg::WORDS_W-1:0]  cur_words_ff, cur_words_in;
   logic                         drop_ff, drop_in;
   logic                         end_ff, end_in;

   logic                         hit;
   logic                         free_here;
   logic                         last_chk;
   efb_pkg::efb_acc_type         acc;

   efb_accum u_accum (
      .fpe        (fpe),
      .cur_count  (cur_count_ff),
      .cur_words  (cur_words_ff),
      .frag_words (frag_words),
      .acc        (acc)
   );

   assign hit       = chk_vld_ff && valid_ff[chk_idx_ff] && (rd_data.evt_num == evt_num);
   assign free_here = chk_vld_ff && !valid_ff[chk_idx_ff];
   assign last_chk  = chk_vld_ff && (chk_idx_ff == IDX_W'(SLOTS - 1));

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      chk_idx_in    = chk_idx_ff;
      chk_vld_in    = 1'b0;
      valid_in      = valid_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      tgt_idx_in    = tgt_idx_ff;
      cur_count_in  = cur_count_ff;
      cur_words_in  = cur_words_ff;
      drop_in       = drop_ff;
      end_in        = end_ff;
      req_ready     = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = cnt_ff[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = tgt_idx_ff;
      wr_data.evt_num  = evt_num;
      wr_data.count    = acc.count;
      wr_data.words    = acc.words;
      res           = '0;

      unique case (state_ff)
         efb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_accept) begin
               end_in        = req_end;
               drop_in       = 1'b0;
               free_found_in = 1'b0;
               if (req_end) begin
                  state_in = efb_pkg::ST_FINISH;
               end else begin
                  // first read goes out with the accept
                  rd_en      = 1'b1;
                  rd_addr    = '0;
                  cnt_in     = CNT_W'(1);
                  chk_idx_in = '0;
                  chk_vld_in = 1'b1;
                  state_in   = efb_pkg::ST_SCAN;
               end
            end
         end
         efb_pkg::ST_SCAN: begin
            if (hit) begin
               tgt_idx_in   = chk_idx_ff;
               cur_count_in = rd_data.count;
               cur_words_in = rd_data.words;
               state_in     = efb_pkg::ST_FINISH;
            end else if (last_chk) begin
               if (free_found_ff || free_here) begin
                  tgt_idx_in = free_found_ff ? free_idx_ff : chk_idx_ff;
               end else begin
                  drop_in = 1'b1;
               end
               cur_count_in = '0;
               cur_words_in = '0;
               state_in     = efb_pkg::ST_FINISH;
            end else begin
               if (free_here && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = chk_idx_ff;
               end
               // keep the read pipe full until the last slot has gone out
               if (cnt_ff < CNT_W'(SLOTS)) begin
                  rd_en      = 1'b1;
                  cnt_in     = cnt_ff + CNT_W'(1);
                  chk_idx_in = cnt_ff[IDX_W-1:0];
                  chk_vld_in = 1'b1;
               end
            end
         end
         efb_pkg::ST_FINISH: begin
            if (out_free) begin
               res.load     = 1'b1;
               res.end_seen = end_ff;
               res.dropped  = drop_ff && !end_ff;
               if (!end_ff && !drop_ff) begin
                  res.complete         = acc.complete;
                  res.words            = acc.words;
                  valid_in[tgt_idx_ff] = !acc.complete;
                  wr_en                = !acc.complete;
               end
               state_in = efb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = efb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= efb_pkg::ST_IDLE;
         chk_vld_ff <= 1'b0;
         valid_ff   <= '0;
         drop_ff    <= 1'b0;
         end_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         chk_vld_ff <= chk_vld_in;
         valid_ff   <= valid_in;
         drop_ff    <= drop_in;
         end_ff     <= end_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      chk_idx_ff    <= chk_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      tgt_idx_ff    <= tgt_idx_in;
      cur_count_ff  <= cur_count_in;
      cur_words_ff  <= cur_words_in;
   end

   a_wr_only_finish: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == efb_pkg::ST_FINISH) && !end_ff && !drop_ff)
      else $error("table write outside update of a stored fragment");

   a_load_to_idle: assert property (@(posedge clock) disable iff (reset)
      res.load |=> (state_ff == efb_pkg::ST_IDLE))
      else $error("sequencer did not return to idle after result");

   a_chk_in_scan: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> (state_ff == efb_pkg::ST_SCAN))
      else $error("read data checked outside scan");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (drop_ff && (state_ff == efb_pkg::ST_FINISH)) |-> (&valid_ff))
      else $error("fragment dropped with a free slot");

   a_complete_frees: assert property (@(posedge clock) disable iff (reset)
      (res.load && res.complete) |=> !valid_ff[$past(tgt_idx_ff)])
      else $error("completed event left its slot valid");

endmodule

// ----- design/event_fragment_builder.sv -----
// Top level of the event fragment builder: ports, config register, beat registers.
//
//   channel  dir  handshake              payload
//   req_     in   req_tvalid/req_tready  tlast end marker, tdata id and word count
//   rsp_     out  rsp_tvalid/rsp_tready  tlast end seen, tuser flags, tdata id and words
//   csr_     in   csr_wr_en              fragments per event, 7 bit
//
// A fragment's scan stops at slot h when it hits slot h, and runs over all SLOTS
// slots when it opens a new event or is dropped: the scan reads the slot memory
// one entry a cycle. An end marker skips the scan.
// Reset clears the valid bits, the sequencer and the output beat; fragments per
// event goes back to 1. A stalled result beat holds in its register while the
// next fragment is taken and scanned; that one waits in its last cycle.
module event_fragment_builder #(
   parameter int SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // evt_num [31:0], fragment_words [47:32]
   input  logic        req_tlast,   // end_marker
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // done_event [31:0], event_words [53:32], zero
   output logic [1:0]  rsp_tuser,   // complete [0], dropped_full [1]
   output logic        rsp_tlast,   // end_seen
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);

   localparam int IDX_W = $clog2(SLOTS);

   logic [efb_pkg::COUNT_W-1:0]  fpe_ff, fpe_in;
   logic [efb_pkg::EVENT_W-1:0]  id_ff, id_in;
   logic [efb_pkg::FRAG_W-1:0]   words_ff, words_in;
   logic                         rsp_vld_ff, rsp_vld_in;
   logic [efb_pkg::EVENT_W-1:0]  rsp_event_ff, rsp_event_in;
   logic [efb_pkg::WORDS_W-1:0]  rsp_words_ff, rsp_words_in;
   logic                         rsp_cmpl_ff, rsp_cmpl_in;
   logic                         rsp_drop_ff, rsp_drop_in;
   logic                         rsp_end_ff, rsp_end_in;

   logic                         req_accept;
   logic                         out_free;
   logic                         rd_en;
   logic [IDX_W-1:0]             rd_addr;
   efb_pkg::efb_entry_type       rd_data;
   logic                         wr_en;
   logic [IDX_W-1:0]             wr_addr;
   efb_pkg::efb_entry_type       wr_data;
   efb_pkg::efb_res_type         res;

   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_vld_ff || rsp_tready;

   efb_slot_ram #(.SLOTS(SLOTS)) u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   efb_ctrl #(.SLOTS(SLOTS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_end    (req_tlast),
      .req_ready  (req_tready),
      .evt_num    (id_ff),
      .frag_words (words_ff),
      .fpe        (fpe_ff),
      .out_free   (out_free),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .res        (res)
   );

   always_comb begin
      fpe_in       = csr_wr_en ? csr_wr_data : fpe_ff;
      id_in        = req_accept ? req_tdata[31:0]  : id_ff;
      words_in     = req_accept ? req_tdata[47:32] : words_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_tready;
      rsp_event_in = rsp_event_ff;
      rsp_words_in = rsp_words_ff;
      rsp_cmpl_in  = rsp_cmpl_ff;
      rsp_drop_in  = rsp_drop_ff;
      rsp_end_in   = rsp_end_ff;
      if (res.load) begin
         rsp_vld_in   = 1'b1;
         rsp_event_in = res.end_seen ? '0 : id_ff;
         rsp_words_in = res.words;
         rsp_cmpl_in  = res.complete;
         rsp_drop_in  = res.dropped;
         rsp_end_in   = res.end_seen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fpe_ff     <= efb_pkg::COUNT_W'(1);
         rsp_vld_ff <= 1'b0;
      end else begin
         fpe_ff     <= fpe_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff        <= id_in;
      words_ff     <= words_in;
      rsp_event_ff <= rsp_event_in;
      rsp_words_ff <= rsp_words_in;
      rsp_cmpl_ff  <= rsp_cmpl_in;
      rsp_drop_ff  <= rsp_drop_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {2'b00, rsp_words_ff, rsp_event_ff};
   assign rsp_tuser  = {rsp_drop_ff, rsp_cmpl_ff};
   assign rsp_tlast  = rsp_end_ff;

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for event_fragment_builder: queued fragment driver, result monitor.
module testbench;

   localparam int NUM_SLOTS  = 16;
   localparam int IDLE_LIMIT = 4000;
   localparam int SETTLE     = NUM_SLOTS + 4;

   typedef struct packed {
      logic                        end_marker;
      logic [efb_pkg::EVENT_W-1:0] evt_num;
      logic [efb_pkg::FRAG_W-1:0]  words;
   } fragment_type;

   typedef struct packed {
      logic                        complete;
      logic [efb_pkg::EVENT_W-1:0] done_event;
      logic [efb_pkg::WORDS_W-1:0] event_words;
      logic                        dropped_full;
      logic                        end_seen;
   } outcome_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata   = '0;   // evt_num [31:0], fragment_words [47:32]
   logic        req_tlast   = 1'b0; // end_marker
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [55:0] rsp_tdata;          // done_event [31:0], event_words [53:32], zero
   logic [1:0]  rsp_tuser;          // complete [0], dropped_full [1]
   logic        rsp_tlast;          // end_seen
   logic        csr_wr_en   = 1'b0;
   logic [6:0]  csr_wr_data = '0;

   // predictor state
   logic                        slot_open  [NUM_SLOTS];
   logic [efb_pkg::EVENT_W-1:0] slot_evt   [NUM_SLOTS];
   logic [efb_pkg::COUNT_W-1:0] slot_frags [NUM_SLOTS];
   logic [efb_pkg::WORDS_W-1:0] slot_total [NUM_SLOTS];
   logic [efb_pkg::COUNT_W-1:0] frags_needed = 7'd1;

   fragment_type frag_queue[$];
   outcome_type  awaited_outcomes[$];
   fragment_type next_frag;
   int unsigned  frags_queued   = 0;
   int unsigned  frags_accepted = 0;
   int unsigned  mismatches     = 0;
   int unsigned  quiet_cycles   = 0;
   int unsigned  send_idle_pct  = 37;
   int unsigned  recv_stall_pct = 77;
   logic         req_beat_taken = 1'b0;

   event_fragment_builder #(.SLOTS(NUM_SLOTS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #6 clock = ~clock;

   // One fragment through the event table: end marker, or find or open a slot (drop if full), count, sum, maybe close.
   function automatic outcome_type build_event_outcome(fragment_type f);
      outcome_type                 o;
      int                          hit;
      int                          free_idx;
      logic [efb_pkg::COUNT_W:0]   thresh;
      logic [efb_pkg::COUNT_W:0]   cnt;
      logic [efb_pkg::WORDS_W:0]   sum;
      o        = '0;
      hit      = -1;
      free_idx = -1;
      if (f.end_marker) begin
         o.end_seen = 1'b1;
         return o;
      end
      o.done_event = f.evt_num;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (slot_open[i]) begin
            if (hit < 0 && slot_evt[i] == f.evt_num) hit = i;
         end else if (free_idx < 0) begin
            free_idx = i;
         end
      end
      if (hit < 0) begin
         if (free_idx < 0) begin
            o.dropped_full = 1'b1;
            return o;
         end
         hit             = free_idx;
         slot_open[hit]  = 1'b1;
         slot_evt[hit]   = f.evt_num;
         slot_frags[hit] = '0;
         slot_total[hit] = '0;
      end
      thresh = (frags_needed == '0) ? efb_pkg::THRESH_ZERO : {1'b0, frags_needed};
      cnt    = {1'b0, slot_frags[hit]} + (efb_pkg::COUNT_W+1)'(1);
      sum    = {1'b0, slot_total[hit]} + (efb_pkg::WORDS_W+1)'(f.words);
      if (sum > {1'b0, efb_pkg::WORDS_MAX}) sum = {1'b0, efb_pkg::WORDS_MAX};
      o.event_words = sum[efb_pkg::WORDS_W-1:0];
      if (cnt >= thresh) begin
         o.complete     = 1'b1;
         slot_open[hit] = 1'b0;
      end else begin
         slot_frags[hit] = cnt[efb_pkg::COUNT_W-1:0];
         slot_total[hit] = sum[efb_pkg::WORDS_W-1:0];
      end
      return o;
   endfunction

   task automatic report_mismatch(string what, outcome_type exp_o, outcome_type got_o);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s: exp cmp=%0b id=%h words=%0d drop=%0b end=%0b",
                  what, exp_o.complete, exp_o.done_event, exp_o.event_words,
                  exp_o.dropped_full, exp_o.end_seen);
         $display("%s: got cmp=%0b id=%h words=%0d drop=%0b end=%0b",
                  what, got_o.complete, got_o.done_event, got_o.event_words,
                  got_o.dropped_full, got_o.end_seen);
      end
   endtask

   // driver: a beat is offered or moved on only after the previous one went
   always @(negedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= recv_stall_pct);
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_beat_taken) begin
         req_beat_taken = 1'b0;
         if (frag_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_frag = frag_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tlast  <= next_frag.end_marker;
            req_tdata  <= {next_frag.words, next_frag.evt_num};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor: results are checked before the new fragment's expectation is queued
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            outcome_type got_o;
            got_o.complete     = rsp_tuser[0];
            got_o.done_event   = rsp_tdata[31:0];
            got_o.event_words  = rsp_tdata[53:32];
            got_o.dropped_full = rsp_tuser[1];
            got_o.end_seen     = rsp_tlast;
            if (awaited_outcomes.size() == 0)
               report_mismatch("unexpected result", '0, got_o);
            else if (got_o !== awaited_outcomes[0])
               report_mismatch("result mismatch", awaited_outcomes.pop_front(), got_o);
            else
               void'(awaited_outcomes.pop_front());
         end
         if (req_tvalid && req_tready) begin
            req_beat_taken = 1'b1;
            frags_accepted++;
            awaited_outcomes.push_back(build_event_outcome(
               '{end_marker: req_tlast, evt_num: req_tdata[31:0], words: req_tdata[47:32]}));
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) || csr_wr_en)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("[event_fragment_builder] ERROR");
            $finish;
         end
      end
   end

   task automatic queue_frag(logic end_marker, logic [31:0] id, logic [15:0] words);
      frag_queue.push_back('{end_marker: end_marker, evt_num: id, words: words});
      frags_queued++;
   endtask

   // hold off until every queued fragment is taken and its result has come back
   task automatic drain();
      while (frags_accepted != frags_queued || awaited_outcomes.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_threshold(logic [6:0] value);
      drain();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en    <= 1'b0;
      frags_needed  = value;
   endtask

   task automatic set_idling(int phase);
      if (phase < 4) begin
         send_idle_pct  = 37;
         recv_stall_pct = 77;
      end else if (phase < 8) begin
         send_idle_pct  = 77;
         recv_stall_pct = 37;
      end else begin
         send_idle_pct  = 0;
         recv_stall_pct = 0;
      end
   endtask

   // Fragments drawn mostly from a pool of live events, so events run to completion;
   // a pool wider than the table forces drops. Some stray ids and end markers mixed in.
   task automatic random_traffic(int count, int pool_n);
      logic [31:0] pool [32];
      int          pick;
      int          roll;
      logic [15:0] w;
      for (int i = 0; i < pool_n; i++) pool[i] = $urandom;
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) drain();
         roll = $urandom_range(99);
         case ($urandom_range(9))
            0:       w = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            1, 2:    w = 16'($urandom);
            default: w = 16'($urandom_range(2000));
         endcase
         if (roll < 3) begin
            queue_frag(1'b1, $urandom, 16'($urandom));
         end else if (roll < 8) begin
            queue_frag(1'b0, $urandom, w);
         end else begin
            pick = $urandom_range(pool_n - 1);
            queue_frag(1'b0, pool[pick], w);
            if ($urandom_range(9) == 0) pool[pick] = $urandom;
         end
      end
   endtask

   initial begin
      logic [6:0]  thresholds [10];
      logic [31:0] sat_id;
      thresholds = '{7'd2, 7'd64, 7'd0, 7'd127, 7'd5, 7'd1, 7'd16, 7'd3, 7'd8, 7'd2};
      for (int i = 0; i < NUM_SLOTS; i++) slot_open[i] = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default of one fragment per event, field extremes and an end marker
      set_idling(0);
      queue_frag(1'b1, 32'hDEADBEEF, 16'h1234);
      queue_frag(1'b0, 32'h0000_0000, 16'h0000);
      queue_frag(1'b0, 32'hFFFF_FFFF, 16'hFFFF);
      queue_frag(1'b0, 32'h5A5A_5A5A, 16'h0001);

      // fill every slot, then overflow the table, then reuse the lowest free slot
      write_threshold(7'd3);
      set_idling(1);
      for (int i = 0; i < NUM_SLOTS; i++) queue_frag(1'b0, 32'd100 + i, 16'hFFFF);
      queue_frag(1'b0, 32'd200, 16'h0010);
      queue_frag(1'b1, 32'h0, 16'h0);
      queue_frag(1'b0, 32'd107, 16'h0002);
      queue_frag(1'b0, 32'd107, 16'h0003);
      queue_frag(1'b0, 32'd300, 16'h0004);

      // full table still drops at one fragment per event; lowered threshold closes the rest
      write_threshold(7'd1);
      queue_frag(1'b0, 32'd400, 16'h0005);
      for (int i = 0; i < NUM_SLOTS; i++)
         queue_frag(1'b0, (i == 7) ? 32'd300 : 32'd100 + i, 16'h0001);

      for (int k = 0; k < 10; k++) begin
         write_threshold(thresholds[k]);
         set_idling(k + 2);
         if (thresholds[k] == 7'd0) begin
            // 130 full-size fragments of one id: the first 128 complete it with the total pinned at its ceiling
            sat_id = $urandom;
            for (int n = 0; n < 130; n++) queue_frag(1'b0, sat_id, 16'hFFFF);
         end
         random_traffic(170, $urandom_range(6, 24));
      end

      drain();
      if (mismatches == 0 && awaited_outcomes.size() == 0)
         $display("[event_fragment_builder] OK");
      else
         $display("[event_fragment_builder] ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
design/efb_pkg.sv
design/efb_accum.sv
design/efb_slot_ram.sv
design/efb_ctrl.sv
design/event_fragment_builder.sv
test/testbench.sv
